// File: rtl/ibc_pkg.sv
`default_nettype none
package ibc_pkg;
   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_FLUSH = 2'd1,
      OP_COEFF = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_HALF   = 2'd2,
      CSR_WIDE   = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DONE
   } state_type;

   localparam int PixelBits = 16;
   localparam int CoeffBits = 18;
endpackage
`default_nettype wire

// File: rtl/image_blur_convolution.sv
`default_nettype none
// Channel | Direction | Fields
// req     | in        | opcode, pixel_value, coeff_index, coeff_value
// rsp     | out       | out_pixel, last_of_frame
// csr     | in        | csr_index, csr_data
// A pixel or flush item that yields a result sweeps all (2s+1)^2 window
// positions, inside the image or not, through the single line-store read port
// feeding one multiply-accumulate unit. No new item is accepted until its
// result is valid. Other items start no sweep, so the block stays ready for
// the next one.
// Reset is synchronous; the line store is not cleared and needs no pass.
// A result that waits holds off the next item until it is taken.
module image_blur_convolution
   import ibc_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HALF_SIZE = 3,
   parameter int COEFF_FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_pixel_value,
   input  wire logic [5:0]  req_coeff_index,
   input  wire logic signed [17:0] req_coeff_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_out_pixel,
   output logic             rsp_last_of_frame,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int Side  = 2 * MAX_HALF_SIZE + 1;
   localparam int KDepth = Side * Side;
   localparam int Rows  = 2 * MAX_HALF_SIZE + 2;
   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int RB    = $clog2(Rows);
   localparam int KB    = $clog2(KDepth);
   localparam int SB    = $clog2(MAX_HALF_SIZE + 1);
   localparam int TB    = $clog2(Side);
   localparam int Depth = Rows * MAX_WIDTH;
   localparam int AB    = $clog2(Depth);

   // configuration
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [1:0]  half_ff;
   logic        wide_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 16'd1;
         half_ff   <= 2'd1;
         wide_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_data[10:0];
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_HALF:   half_ff   <= csr_data[1:0];
            CSR_WIDE:   wide_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [WB-1:0] w;
   logic [16:0]   h;
   logic [SB-1:0] s;
   always_comb begin
      if (width_ff == 11'd0) begin
         w = WB'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w = WB'(MAX_WIDTH);
      end else begin
         w = WB'(width_ff);
      end
      h = (height_ff == 16'd0) ? 17'd1 : {1'b0, height_ff};
      s = (32'(half_ff) > MAX_HALF_SIZE) ? SB'(MAX_HALF_SIZE) : SB'(half_ff);
   end

   // kernel store: valid bits stand in for the all-zero reset
   logic [CoeffBits-1:0] kmem [KDepth];
   logic [KDepth-1:0]    kvalid_ff;
   // line store
   logic [PixelBits-1:0] lmem [Depth];

   // counters
   logic [16:0]   in_row_ff, out_row_ff;
   logic [WB-1:0] in_col_ff, out_col_ff;
   logic [RB-1:0] in_slot_ff, out_slot_ff;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic [15:0] rsp_pixel_ff;
   logic      rsp_last_ff;

   logic accept;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // ready check on the counters after a pixel write
   logic          wr_pix;
   logic          tick;
   logic [16:0]   irow;
   logic [WB-1:0] icol;
   logic [RB-1:0] islot;
   logic [16:0]   nr;
   logic [WB-1:0] nc;
   logic          out_rdy;
   logic [CB-1:0] wcol;
   always_comb begin
      wr_pix = accept && (op_type'(req_opcode) == OP_PIXEL) && (in_row_ff < h);
      // Only pixels and flush ticks may release a result.
      tick = accept && (op_type'(req_opcode) == OP_PIXEL ||
                        op_type'(req_opcode) == OP_FLUSH);
      irow = in_row_ff;
      icol = in_col_ff;
      islot = in_slot_ff;
      wcol = (in_col_ff < w) ? CB'(in_col_ff) : CB'(w - WB'(1));
      if (wr_pix) begin
         if (in_col_ff + WB'(1) >= w) begin
            icol = '0;
            irow = in_row_ff + 17'd1;
            islot = (32'(in_slot_ff) == Rows - 1) ? '0 : in_slot_ff + RB'(1);
         end else begin
            icol = in_col_ff + WB'(1);
         end
      end
      nr = (out_row_ff + 17'(s) < h - 17'd1) ? out_row_ff + 17'(s) : h - 17'd1;
      nc = (out_col_ff + WB'(s) < w - WB'(1)) ? out_col_ff + WB'(s) : w - WB'(1);
      out_rdy = (irow >= h) || (irow > nr) || (irow == nr && icol > nc);
   end

   // window sweep
   logic [TB-1:0] ta_ff, tb_ff;
   logic          go_ff;
   logic signed [17:0] a_s, b_s;
   logic [16:0]   a_row;
   logic [WB-1:0] b_col;
   logic          in_img, last_tap;
   logic [RB-1:0] a_slot;
   logic [KB-1:0] k_idx;
   logic [TB-1:0] side_m1;
   always_comb begin
      side_m1 = TB'({s, 1'b0});
      a_s = $signed({1'b0, out_row_ff}) + 18'(ta_ff) - 18'(s);
      b_s = $signed(18'(out_col_ff)) + 18'(tb_ff) - 18'(s);
      a_row = a_s[16:0];
      b_col = b_s[WB-1:0];
      in_img = !a_s[17] && !b_s[17] && (a_row < h) && (b_col < w);
      a_slot = 32'(out_slot_ff) + 32'(ta_ff) >= Rows + 32'(s)
             ? RB'(32'(out_slot_ff) + 32'(ta_ff) - 32'(s) - Rows)
             : (32'(out_slot_ff) + 32'(ta_ff) < 32'(s)
                ? RB'(32'(out_slot_ff) + 32'(ta_ff) + Rows - 32'(s))
                : RB'(32'(out_slot_ff) + 32'(ta_ff) - 32'(s)));
      k_idx = KB'(32'(ta_ff) * (2 * 32'(s) + 1) + 32'(tb_ff));
      last_tap = (ta_ff == side_m1) && (tb_ff == side_m1);
   end

   logic          rd_ff;
   logic [PixelBits-1:0] rd_pix_ff;
   logic signed [CoeffBits-1:0] rd_coef_ff;
   logic          clear;
   logic [15:0]   mac_out;
   logic          mac_busy;
   assign clear = tick && out_rdy;

   always_ff @(posedge clock) begin
      if (wr_pix) begin
         lmem[AB'(32'(in_slot_ff) * MAX_WIDTH + 32'(wcol))] <=
            wide_ff ? req_pixel_value : {8'd0, req_pixel_value[7:0]};
      end
      rd_pix_ff  <= lmem[AB'(32'(a_slot) * MAX_WIDTH + 32'(b_col[CB-1:0]))];
      rd_coef_ff <= kvalid_ff[k_idx] ? $signed(kmem[k_idx]) : '0;
      if (accept && op_type'(req_opcode) == OP_COEFF && 32'(req_coeff_index) < KDepth) begin
         kmem[KB'(req_coeff_index)] <= req_coeff_value;
      end
   end

   ibc_mac #(.FracBits(COEFF_FRAC_BITS), .AccBits(48)) u_mac (
      .clock(clock), .clear(clear), .tap_valid(rd_ff), .tap_pixel(rd_pix_ff),
      .tap_coeff(rd_coef_ff), .wide(wide_ff), .result(mac_out), .busy(mac_busy)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (clear) state_in = ST_ACC;
         ST_ACC:  if (!go_ff && !rd_ff && !mac_busy) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic out_last;
   logic [16:0]   orow_n;
   logic [WB-1:0] ocol_n;
   logic [RB-1:0] oslot_n;
   always_comb begin
      orow_n = out_row_ff;
      ocol_n = out_col_ff + WB'(1);
      oslot_n = out_slot_ff;
      if (out_col_ff + WB'(1) >= w) begin
         ocol_n = '0;
         orow_n = out_row_ff + 17'd1;
         oslot_n = (32'(out_slot_ff) == Rows - 1) ? '0 : out_slot_ff + RB'(1);
      end
      out_last = orow_n >= h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kvalid_ff <= '0;
         in_row_ff <= '0; in_col_ff <= '0; in_slot_ff <= '0;
         out_row_ff <= '0; out_col_ff <= '0; out_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
         go_ff <= 1'b0; rd_ff <= 1'b0;
         ta_ff <= '0; tb_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && op_type'(req_opcode) == OP_COEFF && 32'(req_coeff_index) < KDepth)
            kvalid_ff[KB'(req_coeff_index)] <= 1'b1;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_DONE && out_last) begin
            in_row_ff <= '0; in_col_ff <= '0; in_slot_ff <= '0;
         end else begin
            in_row_ff <= irow; in_col_ff <= icol; in_slot_ff <= islot;
         end
         rd_ff <= go_ff && in_img;
         if (clear) begin
            go_ff <= 1'b1; ta_ff <= '0; tb_ff <= '0;
         end else if (go_ff) begin
            if (last_tap) go_ff <= 1'b0;
            else if (tb_ff == side_m1) begin
               tb_ff <= '0; ta_ff <= ta_ff + TB'(1);
            end else tb_ff <= tb_ff + TB'(1);
         end
         if (state_ff == ST_DONE) begin
            rsp_pixel_ff <= mac_out;
            rsp_last_ff  <= out_last;
            if (out_last) begin
               out_row_ff <= '0; out_col_ff <= '0; out_slot_ff <= '0;
            end else begin
               out_row_ff <= orow_n; out_col_ff <= ocol_n; out_slot_ff <= oslot_n;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_last_of_frame = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("item accepted while busy");
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid) else $error("result lost");
   a_sweep_in_acc: assert property (@(posedge clock) disable iff (reset)
      go_ff |-> state_ff == ST_ACC) else $error("sweep outside accumulate");
`endif
endmodule
`default_nettype wire

// File: rtl/ibc_mac.sv
`default_nettype none
// Multiply-accumulate unit: one pixel-times-weight product per cycle, with a
// register after the multiplier, and the final round and saturate.
module ibc_mac
   import ibc_pkg::*;
#(
   parameter int FracBits = 16,
   parameter int AccBits  = 48
) (
   input  wire logic                 clock,
   input  wire logic                 clear,
   input  wire logic                 tap_valid,
   input  wire logic [PixelBits-1:0] tap_pixel,
   input  wire logic signed [CoeffBits-1:0] tap_coeff,
   input  wire logic                 wide,
   output logic [PixelBits-1:0]      result,
   output logic                      busy
);
   logic signed [PixelBits+CoeffBits:0] prod_ff, prod_in;
   logic                                pvalid_ff;
   logic signed [AccBits-1:0]           acc_ff, acc_in;
   logic signed [AccBits-1:0]           rounded;
   logic [AccBits-1:0]                  q;
   logic [PixelBits-1:0]                limit;

   assign prod_in = $signed({1'b0, tap_pixel}) * tap_coeff;

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (pvalid_ff) begin
         acc_in = acc_ff + AccBits'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pvalid_ff <= tap_valid & ~clear;
      acc_ff    <= acc_in;
   end

   assign busy    = pvalid_ff;
   assign rounded = acc_ff + (AccBits'(1) <<< (FracBits - 1));
   assign q       = AccBits'(rounded) >> FracBits;
   assign limit   = wide ? 16'hFFFF : 16'h00FF;

   always_comb begin
      if (acc_ff <= 0) begin
         result = '0;
      end else if (q > AccBits'(limit)) begin
         result = limit;
      end else begin
         result = q[PixelBits-1:0];
      end
   end
endmodule
`default_nettype wire

// File: tb/testbench.sv
module testbench
   import ibc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] pixel;
      logic        last;
   } blur_out_type;

   typedef struct {
      op_type             op;
      logic [15:0]        pix;
      logic [5:0]         idx;
      logic signed [17:0] coef;
      bit                 typed;
      logic [15:0]        exp_pixel;
      logic               exp_last;
   } step_row_type;

   localparam int LineWidth = 1024;
   localparam int LineRows  = 8;
   localparam int KernDepth = 49;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   logic [15:0] req_pixel_value;
   logic [5:0] req_coeff_index;
   logic signed [17:0] req_coeff_value;
   logic rsp_valid, rsp_ready;
   logic [15:0] rsp_out_pixel;
   logic rsp_last_of_frame;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_data;

   image_blur_convolution dut (.*);

   // Shadow of the block's state.
   logic [15:0] pix_lines [0:LineRows*LineWidth-1];
   logic signed [17:0] kern [0:KernDepth-1];
   int unsigned irow, icol, orow, ocol;
   logic [10:0] cfg_width;
   logic [15:0] cfg_height;
   logic [1:0]  cfg_half;
   logic        cfg_wide;

   blur_out_type pending_pixels[$];
   bit failed;
   int items_sent;
   int send_idle_pct, recv_idle_pct;
   int hold_cycles;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int unsigned eff_w();
      if (cfg_width < 1) return 1;
      if (cfg_width > LineWidth) return LineWidth;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_h();
      return (cfg_height < 1) ? 1 : cfg_height;
   endfunction

   function automatic logic [15:0] window_sum(int unsigned i, int unsigned j);
      int unsigned w, h, s, a0, a1, b0, b1, side, k;
      longint sum, q, lim;
      w = eff_w();
      h = eff_h();
      s = cfg_half;
      a0 = (i > s) ? i - s : 0;
      b0 = (j > s) ? j - s : 0;
      a1 = (i + s < h - 1) ? i + s : h - 1;
      b1 = (j + s < w - 1) ? j + s : w - 1;
      side = 2 * s + 1;
      lim = cfg_wide ? 65535 : 255;
      sum = 0;
      for (int unsigned a = a0; a <= a1; a++) begin
         for (int unsigned b = b0; b <= b1; b++) begin
            k = (a + s - i) * side + (b + s - j);
            sum += longint'(pix_lines[(a % LineRows) * LineWidth + b]) * longint'(kern[k]);
         end
      end
      if (sum <= 0) return 0;
      q = (sum + 32768) >>> 16;
      return (q > lim) ? lim[15:0] : q[15:0];
   endfunction

   // Advances the shadow state by one item; returns 1 when it yields a pixel.
   function automatic bit blur_step(op_type op, logic [15:0] pix, logic [5:0] idx,
                                    logic signed [17:0] coef, output blur_out_type res);
      int unsigned w, h, s, nr, nc, col;
      bit rdy;
      w = eff_w();
      h = eff_h();
      s = cfg_half;
      res = '0;
      if (op == OP_COEFF) begin
         if (idx < KernDepth) kern[idx] = coef;
         return 0;
      end
      if (op == OP_NONE) return 0;
      if (op == OP_PIXEL && irow < h) begin
         col = (icol < w) ? icol : w - 1;
         pix_lines[(irow % LineRows) * LineWidth + col] = cfg_wide ? pix : {8'h00, pix[7:0]};
         icol++;
         if (icol >= w) begin
            icol = 0;
            irow++;
         end
      end
      nr = (orow + s < h - 1) ? orow + s : h - 1;
      nc = (ocol + s < w - 1) ? ocol + s : w - 1;
      rdy = (irow >= h) || (irow > nr) || (irow == nr && icol > nc);
      if (!rdy) return 0;
      res.pixel = window_sum(orow, ocol);
      ocol++;
      if (ocol >= w) begin
         ocol = 0;
         orow++;
      end
      res.last = (orow >= h);
      if (res.last) begin
         irow = 0;
         icol = 0;
         orow = 0;
         ocol = 0;
      end
      return 1;
   endfunction

   task automatic send_item(op_type op, logic [15:0] pix, logic [5:0] idx,
                            logic signed [17:0] coef);
      blur_out_type res;
      if (items_sent < 600) begin
         send_idle_pct = 9;
         recv_idle_pct = 51;
      end else if (items_sent < 1200) begin
         send_idle_pct = 51;
         recv_idle_pct = 9;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (blur_step(op, pix, idx, coef, res)) pending_pixels.push_back(res);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pixel_value <= pix;
      req_coeff_index <= idx;
      req_coeff_value <= coef;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Waits until every expected pixel has arrived and the block has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(csr_type r, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (r)
         CSR_WIDTH:  cfg_width = value[10:0];
         CSR_HEIGHT: cfg_height = value;
         CSR_HALF:   cfg_half = value[1:0];
         default:    cfg_wide = value[0];
      endcase
   endtask

   task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] s, logic [15:0] wd);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_HALF, s);
      write_reg(CSR_WIDE, wd);
   endtask

   task automatic load_kernel(int style);
      logic signed [17:0] c;
      for (int k = 0; k < KernDepth; k++) begin
         case (style)
            0: c = 18'($urandom_range(0, 6000));
            1: c = 18'(int'($urandom_range(0, 60000)) - 20000);
            default: c = 18'($urandom);
         endcase
         send_item(OP_COEFF, 16'($urandom), 6'(k), c);
      end
   endtask

   function automatic bit frame_open();
      return irow != 0 || icol != 0 || orow != 0 || ocol != 0;
   endfunction

   task automatic run_frame(bit big);
      int left, r;
      left = eff_w() * eff_h();
      while (left > 0) begin
         r = big ? 0 : $urandom_range(0, 99);
         if (r < 82) begin
            case ($urandom_range(0, 9))
               0: send_item(OP_PIXEL, 16'h0000, 6'($urandom), 18'($urandom));
               1: send_item(OP_PIXEL, 16'hFFFF, 6'($urandom), 18'($urandom));
               default: send_item(OP_PIXEL, 16'($urandom), 6'($urandom), 18'($urandom));
            endcase
            left--;
         end else if (r < 90) begin
            send_item(OP_FLUSH, 16'($urandom), 6'($urandom), 18'($urandom));
         end else if (r < 95) begin
            send_item(OP_COEFF, 16'($urandom), 6'($urandom_range(0, 63)),
                      18'(int'($urandom_range(0, 12000)) - 2000));
         end else begin
            send_item(OP_NONE, 16'($urandom), 6'($urandom), 18'($urandom));
         end
      end
      // Pixels beyond the frame are dropped while outputs are still draining.
      while (frame_open()) begin
         if (irow >= eff_h() && $urandom_range(0, 3) == 0)
            send_item(OP_PIXEL, 16'($urandom), 6'($urandom), 18'($urandom));
         else
            send_item(OP_FLUSH, 16'($urandom), 6'($urandom), 18'($urandom));
      end
   endtask

   // Result side: checks each accepted item, then picks the next ready level.
   initial begin
      blur_out_type exp_px;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("unexpected item: out_pixel %0d last_of_frame %0d",
                      rsp_out_pixel, rsp_last_of_frame);
               failed = 1;
            end else begin
               exp_px = pending_pixels.pop_front();
               if (rsp_out_pixel !== exp_px.pixel) begin
                  $error("out_pixel: expected %0d, actual %0d", exp_px.pixel, rsp_out_pixel);
                  failed = 1;
               end
               if (rsp_last_of_frame !== exp_px.last) begin
                  $error("last_of_frame: expected %0d, actual %0d",
                         exp_px.last, rsp_last_of_frame);
                  failed = 1;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      step_row_type rows[$];
      blur_out_type res;
      int phase, w, h;
      failed = 0;
      items_sent = 0;
      hold_cycles = 0;
      send_idle_pct = 9;
      recv_idle_pct = 51;
      irow = 0;
      icol = 0;
      orow = 0;
      ocol = 0;
      cfg_width = 11'd1024;
      cfg_height = 16'd1;
      cfg_half = 2'd1;
      cfg_wide = 1'b0;
      foreach (pix_lines[i]) pix_lines[i] = '0;
      foreach (kern[i]) kern[i] = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_NONE;
      req_pixel_value <= '0;
      req_coeff_index <= '0;
      req_coeff_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_WIDTH;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A zero width and height act as one, so every pixel is a whole frame.
      configure(16'd0, 16'd0, 16'd0, 16'd0);
      rows = '{
         '{OP_PIXEL, 16'h00FF, 6'd0,  18'sd0,       1, 16'd0,   1'b1},
         '{OP_COEFF, 16'h0000, 6'd0,  18'sd65536,   0, 16'd0,   1'b0},
         '{OP_PIXEL, 16'h12FF, 6'd0,  18'sd0,       1, 16'd255, 1'b1},
         '{OP_PIXEL, 16'h0000, 6'd0,  18'sd0,       1, 16'd0,   1'b1},
         '{OP_COEFF, 16'h0000, 6'd0,  18'sd131071,  0, 16'd0,   1'b0},
         '{OP_PIXEL, 16'd200,  6'd0,  18'sd0,       1, 16'd255, 1'b1},
         '{OP_COEFF, 16'h0000, 6'd0,  -18'sd131072, 0, 16'd0,   1'b0},
         '{OP_PIXEL, 16'd10,   6'd0,  18'sd0,       1, 16'd0,   1'b1},
         '{OP_COEFF, 16'h0000, 6'd63, 18'sd5,       0, 16'd0,   1'b0},
         '{OP_PIXEL, 16'd10,   6'd0,  18'sd0,       1, 16'd0,   1'b1},
         '{OP_COEFF, 16'h0000, 6'd0,  18'sd32768,   0, 16'd0,   1'b0},
         '{OP_PIXEL, 16'd1,    6'd0,  18'sd0,       1, 16'd1,   1'b1},
         '{OP_PIXEL, 16'd3,    6'd0,  18'sd0,       1, 16'd2,   1'b1},
         '{OP_NONE,  16'hFFFF, 6'h3F, -18'sd1,      0, 16'd0,   1'b0},
         '{OP_FLUSH, 16'h0000, 6'd0,  18'sd0,       0, 16'd0,   1'b0},
         '{OP_COEFF, 16'h0000, 6'd48, 18'sd1,       0, 16'd0,   1'b0},
         '{OP_PIXEL, 16'hFFFF, 6'd0,  18'sd0,       1, 16'd128, 1'b1}
      };
      foreach (rows[n]) begin
         if (rows[n].typed) begin
            // The predictor still runs so its state follows the block.
            void'(blur_step(rows[n].op, rows[n].pix, rows[n].idx, rows[n].coef, res));
            pending_pixels.push_back('{rows[n].exp_pixel, rows[n].exp_last});
            req_valid <= 1'b1;
            req_opcode <= rows[n].op;
            req_pixel_value <= rows[n].pix;
            req_coeff_index <= rows[n].idx;
            req_coeff_value <= rows[n].coef;
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            items_sent++;
         end else begin
            send_item(rows[n].op, rows[n].pix, rows[n].idx, rows[n].coef);
         end
      end
      drain();

      phase = 0;
      while (items_sent < 1600) begin
         if (phase == 1) begin
            // Widest line: the width field at its top clamps to the line length.
            configure(16'hFFFF, 16'd1, 16'd3, 16'd1);
            load_kernel(0);
            run_frame(1);
         end else begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            h = $urandom_range(0, 8);
            if (phase == 3) begin
               w = 12;
               h = 8;
            end
            write_reg(CSR_HEIGHT, 16'hFFFF);
            configure(16'(w | ($urandom_range(0, 31) << 11)), 16'(h),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 1)));
            load_kernel($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2));
            if (phase == 3) hold_cycles = 400;
            repeat ($urandom_range(1, 3)) run_frame(0);
         end
         drain();
         phase++;
      end

      if (!failed) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
